>>> src/uasa_pkg.sv
// Shared types and constants for the upwind advection stencil assembly block.
package uasa_pkg;

  localparam logic [2:0] REG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] REG_STEP_X      = 3'd2;
  localparam logic [2:0] REG_STEP_Y      = 3'd3;
  localparam logic [2:0] REG_MODE        = 3'd4;

  localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
  localparam logic [31:0] RST_STEP        = 32'h0001_0000;

  localparam logic [1:0] MODE_ADV  = 2'd0;
  localparam logic [1:0] MODE_XDER = 2'd1;
  localparam logic [1:0] MODE_YDER = 2'd2;

  localparam int MAG_W = 34;

  typedef enum logic [4:0] {
    ENT_C = 5'b00001,
    ENT_E = 5'b00010,
    ENT_W = 5'b00100,
    ENT_N = 5'b01000,
    ENT_S = 5'b10000
  } entry_t;

  typedef struct packed {
    logic [MAG_W-1:0] m1;
    logic [MAG_W-1:0] m2;
    logic [31:0]      h1;
    logic [31:0]      h2;
    logic             neg;
    logic [12:0]      row;
    logic [13:0]      col;
    logic             last;
  } op_t;

endpackage

>>> src/upwind_advection_stencil_assembly.sv
// Top level: upwind advection stencil assembly, one grid cell in, five matrix entries out.
//
// Input channel in_*: one transaction per grid cell, in raster order (x fastest),
// carrying four face velocities and their four derivatives, signed Q16.16.
// Output channel out_*: five transactions per cell, in the order centre, east,
// west, north, south; out_tlast marks the south entry. An entry whose
// neighbour lies off the grid carries row w_eff*h_eff, the clamped grid size (discard).
// Configuration port cfg_*: APB-style, registers at byte addresses 0,4,..,16:
// grid_width, grid_height, step_x, step_y, mode. Write only while idle.
// Each entry passes the operand, multiply and output registers in turn. The
// single result channel carries all five entries of a cell; the entry sequencer
// feeds one entry per cycle, while the receiver is not stalling, into a
// three-stage operand / split-multiply / round-and-saturate pipeline.
// A new cell is taken while the previous one is still being emitted.
// Reset clears the valid flags, the cell position and the registers to
// 64x64, spacing 1.0, mode 0. When the receiver stalls, the whole entry
// pipeline holds; the input register still accepts one cell ahead.
module upwind_advection_stencil_assembly
  import uasa_pkg::*;
#(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // vel_0, vel_1, vel_2, vel_3, dvel_0, dvel_1, dvel_2, dvel_3 (32 bits each)
  input  logic [255:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row_index[12:0], col_index[26:13], entry_value[58:27], zero pad[63:59]
  output logic [63:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int XW = ($clog2(MAX_WIDTH) < 7) ? $clog2(MAX_WIDTH) : 7;
  localparam int YW = ($clog2(MAX_HEIGHT) < 7) ? $clog2(MAX_HEIGHT) : 7;

  // configuration
  logic [6:0]  grid_width_r, grid_height_r;
  logic [31:0] step_x_r, step_y_r;
  logic [1:0]  mode_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= RST_GRID_WIDTH;
      grid_height_r <= RST_GRID_HEIGHT;
      step_x_r      <= RST_STEP;
      step_y_r      <= RST_STEP;
      mode_r        <= MODE_ADV;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[4:2])
        REG_GRID_WIDTH:  grid_width_r  <= cfg_pwdata[6:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_pwdata[6:0];
        REG_STEP_X:      step_x_r      <= cfg_pwdata;
        REG_STEP_Y:      step_y_r      <= cfg_pwdata;
        REG_MODE:        mode_r        <= cfg_pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_GRID_WIDTH:  cfg_prdata = {25'd0, grid_width_r};
      REG_GRID_HEIGHT: cfg_prdata = {25'd0, grid_height_r};
      REG_STEP_X:      cfg_prdata = step_x_r;
      REG_STEP_Y:      cfg_prdata = step_y_r;
      REG_MODE:        cfg_prdata = {30'd0, mode_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // handshake and pipeline control
  logic   in_valid_r, p_valid_r, m_valid_r, out_valid_r;
  logic   adv, issue, in_acc, last_issue;
  entry_t ent_r, ent_nxt;

  assign adv        = !out_valid_r || out_tready;
  assign issue      = adv && in_valid_r;
  assign last_issue = issue && (ent_r == ENT_S);
  assign in_tready  = !in_valid_r || (adv && (ent_r == ENT_S));
  assign in_acc     = in_tvalid && in_tready;

  logic signed [31:0] vel_r [4];
  logic signed [31:0] dvel_r [4];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 4; i++) begin
        vel_r[i]  <= in_tdata[32*i +: 32];
        dvel_r[i] <= in_tdata[128 + 32*i +: 32];
      end
    end
  end

  always_comb begin
    unique case (ent_r)
      ENT_C:   ent_nxt = ENT_E;
      ENT_E:   ent_nxt = ENT_W;
      ENT_W:   ent_nxt = ENT_N;
      ENT_N:   ent_nxt = ENT_S;
      ENT_S:   ent_nxt = ENT_C;
      default: ent_nxt = ENT_C;
    endcase
  end

  // cell position
  logic [XW-1:0] cell_x_r, cell_x_nxt, ex;
  logic [YW-1:0] cell_y_r, cell_y_nxt, ey;
  logic [6:0]    w_eff, h_eff;
  logic          x_ovf, x_wrap, y_wrap;
  logic [YW:0]   ey1;
  logic [7:0]    nx, ny1;
  logic [14:0]   k, k_e, k_w, k_n, k_s;
  logic [13:0]   off;
  logic [12:0]   row_e, row_w, row_n, row_s;

  always_comb begin
    if (grid_width_r == 7'd0)
      w_eff = 7'd1;
    else if (32'(grid_width_r) > 32'(MAX_WIDTH))
      w_eff = 7'(MAX_WIDTH);
    else
      w_eff = grid_width_r;
    if (grid_height_r == 7'd0)
      h_eff = 7'd1;
    else if (32'(grid_height_r) > 32'(MAX_HEIGHT))
      h_eff = 7'(MAX_HEIGHT);
    else
      h_eff = grid_height_r;

    x_ovf = 7'(cell_x_r) >= w_eff;
    ex    = x_ovf ? '0 : cell_x_r;
    ey1   = x_ovf ? ({1'b0, cell_y_r} + 1'b1) : {1'b0, cell_y_r};
    ey    = (8'(ey1) >= 8'(h_eff)) ? '0 : ey1[YW-1:0];

    nx     = 8'(ex) + 8'd1;
    ny1    = 8'(ey) + 8'd1;
    x_wrap = nx >= 8'(w_eff);
    y_wrap = ny1 >= 8'(h_eff);
    cell_x_nxt = x_wrap ? '0 : nx[XW-1:0];
    cell_y_nxt = x_wrap ? (y_wrap ? '0 : ny1[YW-1:0]) : ey;

    k   = 15'(ey) * 15'(w_eff) + 15'(ex);
    off = 14'(w_eff) * 14'(h_eff);
    k_e = k + 15'd1;
    k_w = k - 15'd1;
    k_n = k + 15'(w_eff);
    k_s = k - 15'(w_eff);
    row_e = (7'(ex) == w_eff - 7'd1) ? off[12:0] : k[12:0];
    row_w = (ex == '0) ? off[12:0] : k[12:0];
    row_n = (7'(ey) == h_eff - 7'd1) ? off[12:0] : k[12:0];
    row_s = (ey == '0) ? off[12:0] : k[12:0];
  end

  // operand terms
  function automatic logic [MAG_W-1:0] pos2(input logic signed [31:0] g);
    logic [MAG_W-1:0] r;
    r = (g > 0) ? {2'b00, g[30:0], 1'b0} : '0;
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] neg2(input logic signed [31:0] g);
    logic signed [32:0] n;
    logic [MAG_W-1:0]   r;
    n = -(33'(g));
    r = (g < 0) ? {n, 1'b0} : '0;
    return r;
  endfunction

  // s*d + d
  function automatic logic signed [34:0] dplus(input logic signed [31:0] g,
                                               input logic signed [31:0] d);
    logic signed [34:0] r;
    if (g > 0)       r = 35'(d) <<< 1;
    else if (g == 0) r = 35'(d);
    else             r = '0;
    return r;
  endfunction

  // s*d - d
  function automatic logic signed [34:0] dminus(input logic signed [31:0] g,
                                                input logic signed [31:0] d);
    logic signed [34:0] r;
    if (g > 0)       r = '0;
    else if (g == 0) r = -(35'(d));
    else             r = -(35'(d) <<< 1);
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag(input logic signed [34:0] s);
    logic signed [34:0] a;
    a = s[34] ? -s : s;
    return a[MAG_W-1:0];
  endfunction

  op_t op_nxt, op_r;
  logic signed [34:0] s_sel;

  always_comb begin
    op_nxt      = '0;
    s_sel       = '0;
    op_nxt.last = (ent_r == ENT_S);
    unique case (ent_r)
      ENT_C: begin op_nxt.row = k[12:0]; op_nxt.col = k[13:0];   end
      ENT_E: begin op_nxt.row = row_e;   op_nxt.col = k_e[13:0]; end
      ENT_W: begin op_nxt.row = row_w;   op_nxt.col = k_w[13:0]; end
      ENT_N: begin op_nxt.row = row_n;   op_nxt.col = k_n[13:0]; end
      ENT_S: begin op_nxt.row = row_s;   op_nxt.col = k_s[13:0]; end
      default: ;
    endcase
    unique case (mode_r)
      MODE_XDER: begin
        op_nxt.h1 = step_y_r;
        unique case (ent_r)
          ENT_C:   s_sel = dplus(vel_r[0], dvel_r[0]) + dminus(vel_r[2], dvel_r[2]);
          ENT_E:   s_sel = -dminus(vel_r[0], dvel_r[0]);
          ENT_W:   s_sel = -dplus(vel_r[2], dvel_r[2]);
          default: s_sel = '0;
        endcase
        op_nxt.m1  = mag(s_sel);
        op_nxt.neg = s_sel[34];
      end
      MODE_YDER: begin
        op_nxt.h1 = step_x_r;
        unique case (ent_r)
          ENT_C:   s_sel = dplus(vel_r[1], dvel_r[1]) + dminus(vel_r[3], dvel_r[3]);
          ENT_N:   s_sel = -dminus(vel_r[1], dvel_r[1]);
          ENT_S:   s_sel = -dplus(vel_r[3], dvel_r[3]);
          default: s_sel = '0;
        endcase
        op_nxt.m1  = mag(s_sel);
        op_nxt.neg = s_sel[34];
      end
      default: begin
        op_nxt.neg = 1'b1;
        unique case (ent_r)
          ENT_C: begin
            op_nxt.m1  = pos2(vel_r[0]) + neg2(vel_r[2]);
            op_nxt.h1  = step_y_r;
            op_nxt.m2  = pos2(vel_r[1]) + neg2(vel_r[3]);
            op_nxt.h2  = step_x_r;
            op_nxt.neg = 1'b0;
          end
          ENT_E: begin op_nxt.m1 = neg2(vel_r[0]); op_nxt.h1 = step_y_r; end
          ENT_W: begin op_nxt.m1 = pos2(vel_r[2]); op_nxt.h1 = step_y_r; end
          ENT_N: begin op_nxt.m1 = neg2(vel_r[1]); op_nxt.h1 = step_x_r; end
          ENT_S: begin op_nxt.m1 = pos2(vel_r[3]); op_nxt.h1 = step_x_r; end
          default: ;
        endcase
      end
    endcase
  end

  // multiply stage: spacing split into 16-bit halves
  logic [49:0] pa1_r, pb1_r, pa2_r, pb2_r;
  logic        m_neg_r, m_last_r;
  logic [12:0] m_row_r;
  logic [13:0] m_col_r;

  // round and saturate
  logic [51:0] sum_a, sum_b, q;
  logic [31:0] value;

  always_comb begin
    sum_a = 52'(pa1_r) + 52'(pa2_r);
    sum_b = 52'(pb1_r) + 52'(pb2_r) + 52'h1_0000;
    q     = (sum_a + (sum_b >> 16)) >> 1;
    if (m_neg_r)
      value = (q >= 52'h8000_0000) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    else
      value = (q > 52'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  end

  logic [12:0] out_row_r;
  logic [13:0] out_col_r;
  logic [31:0] out_val_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r       <= op_nxt;
      pa1_r      <= 50'(op_r.m1) * 50'(op_r.h1[31:16]);
      pb1_r      <= 50'(op_r.m1) * 50'(op_r.h1[15:0]);
      pa2_r      <= 50'(op_r.m2) * 50'(op_r.h2[31:16]);
      pb2_r      <= 50'(op_r.m2) * 50'(op_r.h2[15:0]);
      m_neg_r    <= op_r.neg;
      m_row_r    <= op_r.row;
      m_col_r    <= op_r.col;
      m_last_r   <= op_r.last;
      out_row_r  <= m_row_r;
      out_col_r  <= m_col_r;
      out_val_r  <= value;
      out_last_r <= m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      p_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      ent_r       <= ENT_C;
      cell_x_r    <= '0;
      cell_y_r    <= '0;
    end else begin
      if (in_acc)
        in_valid_r <= 1'b1;
      else if (last_issue)
        in_valid_r <= 1'b0;
      if (adv) begin
        p_valid_r   <= issue;
        m_valid_r   <= p_valid_r;
        out_valid_r <= m_valid_r;
      end
      if (issue)
        ent_r <= ent_nxt;
      if (last_issue) begin
        cell_x_r <= cell_x_nxt;
        cell_y_r <= cell_y_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_val_r, out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

endmodule

>>> verif/upwind_advection_stencil_assembly_test.sv
// Self-checking testbench for the upwind advection stencil assembly block.
module upwind_advection_stencil_assembly_test;
  import uasa_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 12;
  localparam int CELLS_PER_PHASE = 38;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [12:0] row;
    logic [13:0] col;
    logic [31:0] value;
    logic        last;
  } stencil_entry_t;

  typedef struct packed {
    bit               is_write;
    logic [2:0]       reg_idx;
    logic [31:0]      wdata;
    logic [3:0][31:0] vel;
    logic [3:0][31:0] dvel;
    bit               typed;
    logic [4:0][31:0] typed_val;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         out_tlast;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [4:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  upwind_advection_stencil_assembly #(
    .MAX_WIDTH(MAX_COLS),
    .MAX_HEIGHT(MAX_ROWS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow registers and cell position
  logic [6:0]  grid_cols = RST_GRID_WIDTH;
  logic [6:0]  grid_rows = RST_GRID_HEIGHT;
  logic [31:0] spacing_x = RST_STEP;
  logic [31:0] spacing_y = RST_STEP;
  logic [1:0]  stencil_mode = MODE_ADV;
  int          cell_x = 0;
  int          cell_y = 0;

  stencil_entry_t   pending_entries[$];
  stencil_entry_t   head;
  stim_row_t        directed_rows[$];
  bit               typed_now = 1'b0;
  logic [4:0][31:0] typed_vals_now = '0;
  int               errors = 0;
  int               entry_count = 0;
  int               quiet_cycles = 0;
  int               gap_pct = 0;
  int               stall_pct = 0;
  int               gap_pct_of[4] = '{0, 46, 0, 21};
  int               stall_pct_of[4] = '{0, 0, 46, 21};

  function automatic longint sign_of(longint v);
    if (v > 0) return 1;
    if (v < 0) return -1;
    return 0;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // (m1*h1 + m2*h2) / 2^17, rounded half away from zero, saturated
  function automatic logic [31:0] half_scaled(longint unsigned m1, longint unsigned h1,
                                              longint unsigned m2, longint unsigned h2,
                                              bit neg);
    longint unsigned hi, lo, q;
    hi = m1 * (h1 >> 16) + m2 * (h2 >> 16);
    lo = m1 * (h1 & 64'hFFFF) + m2 * (h2 & 64'hFFFF) + 64'h1_0000;
    q = (hi + (lo >> 16)) >> 1;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  function automatic logic [31:0] half_scaled_signed(longint s, logic [31:0] h);
    return half_scaled(longint'(magnitude(s)), h, 0, 0, s < 0);
  endfunction

  function automatic void predict_cell(logic [255:0] data, bit typed,
                                       logic [4:0][31:0] typed_val);
    int w, h, k, off;
    longint g[4], d[4];
    logic [4:0][31:0] val;
    int rowv[5], colv[5];
    stencil_entry_t ent;
    w = int'(grid_cols);
    h = int'(grid_rows);
    if (w < 1) w = 1;
    if (w > MAX_COLS) w = MAX_COLS;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    if (cell_x >= w) begin
      cell_x = 0;
      cell_y++;
    end
    if (cell_y >= h) cell_y = 0;
    for (int i = 0; i < 4; i++) begin
      g[i] = longint'($signed(data[32*i +: 32]));
      d[i] = longint'($signed(data[128+32*i +: 32]));
    end
    case (stencil_mode)
      MODE_XDER: begin
        val[0] = half_scaled_signed(sign_of(g[0])*d[0] + d[0] + sign_of(g[2])*d[2] - d[2],
                                    spacing_y);
        val[1] = half_scaled_signed(-(sign_of(g[0])*d[0] - d[0]), spacing_y);
        val[2] = half_scaled_signed(-(sign_of(g[2])*d[2] + d[2]), spacing_y);
        val[3] = '0;
        val[4] = '0;
      end
      MODE_YDER: begin
        val[0] = half_scaled_signed(sign_of(g[1])*d[1] + d[1] + sign_of(g[3])*d[3] - d[3],
                                    spacing_x);
        val[1] = '0;
        val[2] = '0;
        val[3] = half_scaled_signed(-(sign_of(g[1])*d[1] - d[1]), spacing_x);
        val[4] = half_scaled_signed(-(sign_of(g[3])*d[3] + d[3]), spacing_x);
      end
      default: begin
        val[0] = half_scaled(longint'(magnitude(g[0]) + g[0] + magnitude(g[2]) - g[2]),
                             spacing_y,
                             longint'(magnitude(g[1]) + g[1] + magnitude(g[3]) - g[3]),
                             spacing_x, 1'b0);
        val[1] = half_scaled_signed(-(magnitude(g[0]) - g[0]), spacing_y);
        val[2] = half_scaled_signed(-(magnitude(g[2]) + g[2]), spacing_y);
        val[3] = half_scaled_signed(-(magnitude(g[1]) - g[1]), spacing_x);
        val[4] = half_scaled_signed(-(magnitude(g[3]) + g[3]), spacing_x);
      end
    endcase
    k = cell_y * w + cell_x;
    off = w * h;
    rowv[0] = k;
    rowv[1] = (cell_x == w - 1) ? off : k;
    rowv[2] = (cell_x == 0) ? off : k;
    rowv[3] = (cell_y == h - 1) ? off : k;
    rowv[4] = (cell_y == 0) ? off : k;
    colv[0] = k;
    colv[1] = k + 1;
    colv[2] = k - 1;
    colv[3] = k + w;
    colv[4] = k - w;
    for (int i = 0; i < 5; i++) begin
      ent.row = 13'(rowv[i]);
      ent.col = 14'(colv[i]);
      ent.value = typed ? typed_val[i] : val[i];
      ent.last = (i == 4);
      pending_entries.push_back(ent);
    end
    cell_x++;
    if (cell_x >= w) begin
      cell_x = 0;
      cell_y++;
      if (cell_y >= h) cell_y = 0;
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch at entry %0d, %s: got %h, want %h", entry_count, field, got, want);
    errors++;
  endtask

  // transaction monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_cell(in_tdata, typed_now, typed_vals_now);
      if (out_tvalid && out_tready) begin
        if (pending_entries.size() == 0) begin
          report_mismatch("entry with none pending", out_tdata[31:0], '0);
        end else begin
          head = pending_entries.pop_front();
          if (out_tdata[12:0] !== head.row)
            report_mismatch("row_index", 32'(out_tdata[12:0]), 32'(head.row));
          if (out_tdata[26:13] !== head.col)
            report_mismatch("col_index", 32'(out_tdata[26:13]), 32'(head.col));
          if (out_tdata[58:27] !== head.value)
            report_mismatch("entry_value", out_tdata[58:27], head.value);
          if (out_tlast !== head.last)
            report_mismatch("last_entry", 32'(out_tlast), 32'(head.last));
          if (out_tdata[63:59] !== 5'd0)
            report_mismatch("pad", 32'(out_tdata[63:59]), '0);
        end
        entry_count++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void add_write(logic [2:0] idx, logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_idx = idx;
    r.wdata = value;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_cell(logic [31:0] v0, v1, v2, v3, d0, d1, d2, d3,
                                   bit typed = 1'b0, logic [31:0] c = '0, e = '0,
                                   w = '0, n = '0, s = '0);
    stim_row_t r;
    r = '0;
    r.vel = {v3, v2, v1, v0};
    r.dvel = {d3, d2, d1, d0};
    r.typed = typed;
    r.typed_val = {s, n, w, e, c};
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed_rows();
    // reset setup: 64x64, unit spacing, advection
    add_cell('0, '0, '0, '0, '0, '0, '0, '0, 1, '0, '0, '0, '0, '0);
    add_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0, '0, '0, '0,
             1, 32'h0002_0000, '0, 32'hFFFF_0000, '0, 32'hFFFF_0000);
    add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             1, 32'h7FFF_FFFF, '0, 32'h8000_0001, '0, 32'h8000_0001);
    add_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             1, 32'h7FFF_FFFF, 32'h8000_0000, '0, 32'h8000_0000, '0);
    add_cell(32'h0001_2345, 32'hFFFE_DCBB, 32'h0000_0000, 32'h8000_0001,
             32'h7FFF_FFFF, 32'h0000_8000, 32'hFFFF_8000, 32'h8000_0000);
    add_cell(32'hFFFF_FFFF, 32'h0000_0001, 32'hC000_0000, 32'h4000_0000,
             32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
    add_write(REG_STEP_X, 32'hFFFF_FFFF);
    add_write(REG_STEP_Y, 32'h0000_0000);
    add_cell(32'h0003_8000, 32'hFFFC_8000, 32'hFFFF_FFFF, 32'h0000_0001, '0, '0, '0, '0);
    add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, '0);
    add_write(REG_STEP_Y, 32'hFFFF_FFFF);
    add_write(REG_MODE, 32'(MODE_XDER));
    // zero velocity: sign counts as zero
    add_cell('0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345, 32'hFFFF_0000);
    add_cell(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h0000_4000, 32'h8000_0000, 32'hFFFF_C000);
    add_write(REG_MODE, 32'(MODE_YDER));
    add_cell('0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_2345, 32'hFFFF_0000);
    add_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_cell(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
             32'h0002_0000, 32'h7FFF_FFFF, 32'h0000_0003, 32'h8000_0000);
    add_write(REG_STEP_X, 32'h0001_8000);
    add_write(REG_MODE, 32'(MODE_SPARE));
    add_cell(32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, '0, '0, '0, '0);
    add_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0, '0, '0);
    // zero size clamps to 1x1; position lands beyond the shrunk grid
    add_write(REG_GRID_WIDTH, 32'd0);
    add_write(REG_GRID_HEIGHT, 32'd0);
    add_write(REG_MODE, 32'(MODE_ADV));
    add_cell(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, '0, '0, '0, '0);
    add_cell(32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, '0, '0, '0, '0);
    add_write(REG_GRID_WIDTH, 32'd127);
    add_write(REG_GRID_HEIGHT, 32'd3);
    add_cell(32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 32'h0000_0400, '0, '0, '0, '0);
    add_cell(32'hFFFF_FF00, 32'hFFFF_FE00, 32'hFFFF_FD00, 32'hFFFF_FC00, '0, '0, '0, '0);
    add_write(REG_GRID_WIDTH, 32'hFFFF_FF82);
    add_write(REG_GRID_HEIGHT, 32'd127);
    add_cell(32'h0000_0001, '0, '0, '0, '0, '0, '0, '0);
    add_cell('0, 32'h0000_0001, '0, '0, '0, '0, '0, '0);
    add_cell('0, '0, 32'h8000_0000, '0, '0, '0, '0, '0);
  endfunction

  function automatic logic [31:0] pick_q16();
    case ($urandom_range(7))
      0: return '0;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return ($urandom_range(1) != 0) ? 32'($urandom_range(32'h3_FFFF))
                                         : -32'($urandom_range(32'h3_FFFF));
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_row_t random_cell();
    stim_row_t r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r.vel[i] = pick_q16();
      r.dvel[i] = pick_q16();
    end
    return r;
  endfunction

  function automatic logic [31:0] pick_dim();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(7))
      0: v[6:0] = 7'd0;
      1: v[6:0] = 7'd127;
      2: v[6:0] = 7'd64;
      3: v[6:0] = 7'd1;
      4: v[6:0] = 7'($urandom_range(65, 126));
      default: v[6:0] = 7'($urandom_range(2, 8));
    endcase
    return v;
  endfunction

  function automatic logic [31:0] pick_spacing();
    case ($urandom_range(5))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_entries.size() != 0);
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  grid_cols = value[6:0];
      REG_GRID_HEIGHT: grid_rows = value[6:0];
      REG_STEP_X:      spacing_x = value;
      REG_STEP_Y:      spacing_y = value;
      REG_MODE:        stencil_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic send_cell(stim_row_t r, int gap);
    if ($urandom_range(99) < gap) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {r.dvel, r.vel};
    typed_now <= r.typed;
    typed_vals_now <= r.typed_val;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [31:0] mode_word;
    build_directed_rows();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        wait_drained();
        apb_write(directed_rows[i].reg_idx, directed_rows[i].wdata);
      end else begin
        send_cell(directed_rows[i], 0);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      mode_word = $urandom;
      mode_word[1:0] = 2'($urandom_range(3));
      apb_write(REG_GRID_WIDTH, pick_dim());
      apb_write(REG_GRID_HEIGHT, pick_dim());
      apb_write(REG_STEP_X, pick_spacing());
      apb_write(REG_STEP_Y, pick_spacing());
      apb_write(REG_MODE, mode_word);
      gap_pct = gap_pct_of[phase % 4];
      stall_pct = stall_pct_of[phase % 4];
      for (int n = 0; n < CELLS_PER_PHASE; n++) begin
        if (phase == 2 && n == CELLS_PER_PHASE / 2) wait_drained();
        send_cell(random_cell(), gap_pct);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_entries.size() != 0)
      report_mismatch("entries never delivered", 32'(pending_entries.size()), '0);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/uasa_pkg.sv
src/upwind_advection_stencil_assembly.sv
verif/upwind_advection_stencil_assembly_test.sv
